@@ design/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// consequence that must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ design/tsp_pkg.sv @@
package tsp_pkg;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_GAP_MS      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUAL_OUTPUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REST_LEVEL  = 2'd2;

   localparam logic [9:0] GAP_MS_RESET = 10'd10;

   localparam int FREQ_W    = 16;
   localparam int DUR_W     = 16;
   localparam int ELAPSED_W = 16;

   localparam logic [3:0] RES_MIN_BITS = 4'd4;
   localparam logic [3:0] RES_MAX_BITS = 4'd13;

   // wide enough for the frequency shifted left by the widest resolution less one
   localparam int SHIFT_W = FREQ_W + 12;

   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  entry_index;
      logic [15:0] entry_freq;
      logic [15:0] entry_duration;
      logic [6:0]  seq_length;
   } tsp_req_type;

   typedef struct packed {
      logic [15:0] tone_freq;
      logic [3:0]  res_width;
      logic [12:0] duty_value;
      logic        playing;
      logic        second_enabled;
   } tsp_rsp_type;

   typedef struct packed {
      logic capture;
      logic apply;
      logic update;
      logic load_freq;
      logic res_init;
      logic res_step;
      logic emit;
   } tsp_cmd_type;

   typedef struct packed {
      logic fetch_tick;
      logic fetch_load;
      logic need_load;
      logic res_done;
   } tsp_status_type;

endpackage

@@ design/tone_sequence_player_top.sv @@
// tone sequence player: plays a stored table of tones for a buzzer pwm.
// items come in on req_data and are taken at a clock edge with start high
// and busy low. mode write loads a table entry and stops playback, mode
// start plays the first seq_length entries from entry 0, mode tick
// advances playback by one millisecond.
// every item gives one result on rsp_data, valid for the single cycle in
// which rsp_strobe is high; the receiver cannot hold it off.
// before the strobe the item passes through the apply state,
// up to two table reads for a tick, then the pwm resolution search,
// which tries one resolution per cycle, from 4 up to 13 bits.
// busy drops in the strobe cycle, so the next item may be taken there.
// the csr port writes gap_ms, dual_output and the rest pin level at any
// edge with csr_we high; write them only while busy is low and no strobe
// is due.
// synchronous reset stops playback, sets gap_ms to 10 and leaves the
// tone table undefined until written.
module tone_sequence_player_top #(
   parameter int MAX_TONES = 64,
   parameter int CLOCK_HZ  = 80000000
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  tsp_pkg::tsp_req_type           req_data,
   output logic                           rsp_strobe,
   output tsp_pkg::tsp_rsp_type           rsp_data,
   input  logic                           csr_we,
   input  logic [tsp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tsp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tsp_pkg::*;

   tsp_cmd_type    cmd;
   tsp_status_type status;

   tsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   tsp_datapath #(
      .MAX_TONES (MAX_TONES),
      .CLOCK_HZ  (CLOCK_HZ)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/tsp_ctrl.sv @@
`include "assert_macros.svh"

module tsp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  tsp_pkg::tsp_status_type status,
   output logic                    busy,
   output logic                    rsp_strobe,
   output tsp_pkg::tsp_cmd_type    cmd
);
   import tsp_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_APPLY    = 4'd1;
   localparam logic [3:0] ST_FETCH_T  = 4'd2;
   localparam logic [3:0] ST_UPDATE   = 4'd3;
   localparam logic [3:0] ST_FETCH_L  = 4'd4;
   localparam logic [3:0] ST_LOAD     = 4'd5;
   localparam logic [3:0] ST_RES_INIT = 4'd6;
   localparam logic [3:0] ST_RES_RUN  = 4'd7;
   localparam logic [3:0] ST_RESPOND  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_strobe_ff;
   logic       accept;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_strobe_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            priority if (status.fetch_tick) state_in = ST_FETCH_T;
            else if (status.fetch_load)     state_in = ST_FETCH_L;
            else                            state_in = ST_RES_INIT;
         end
         ST_FETCH_T:  state_in = ST_UPDATE;
         ST_UPDATE: begin
            state_in = status.need_load ? ST_FETCH_L : ST_RES_INIT;
         end
         ST_FETCH_L:  state_in = ST_LOAD;
         ST_LOAD:     state_in = ST_RES_INIT;
         ST_RES_INIT: state_in = ST_RES_RUN;
         ST_RES_RUN: begin
            if (status.res_done) state_in = ST_RESPOND;
         end
         ST_RESPOND:  state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.capture   = accept;
      cmd.apply     = (state_ff == ST_APPLY);
      cmd.update    = (state_ff == ST_UPDATE);
      cmd.load_freq = (state_ff == ST_LOAD);
      cmd.res_init  = (state_ff == ST_RES_INIT);
      cmd.res_step  = (state_ff == ST_RES_RUN) && !status.res_done;
      cmd.emit      = (state_ff == ST_RESPOND);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == ST_RESPOND);
      end
   end

   `ASSERT_NEXT(a_respond_strobe, clock, reset, state_ff == ST_RESPOND, rsp_strobe_ff)
   `ASSERT_PROP(a_strobe_idle, clock, reset, !rsp_strobe_ff || !busy)
   `ASSERT_NEXT(a_accept_apply, clock, reset, accept, state_ff == ST_APPLY)

endmodule

@@ design/tsp_datapath.sv @@
`include "assert_macros.svh"

module tsp_datapath #(
   parameter int MAX_TONES = 64,
   parameter int CLOCK_HZ  = 80000000
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tsp_pkg::tsp_req_type              req_data,
   input  logic                              csr_we,
   input  logic [tsp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tsp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  tsp_pkg::tsp_cmd_type              cmd,
   output tsp_pkg::tsp_status_type           status,
   output tsp_pkg::tsp_rsp_type              rsp_data
);
   import tsp_pkg::*;

   localparam int IDX_W = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
   localparam int LEN_W = $clog2(MAX_TONES + 1);
   localparam logic [31:0] TONES_U = 32'(MAX_TONES);
   // floor(clk / (1024 f)) equals floor(floor(clk / 1024) / f)
   localparam logic [31:0] RES_NUM = 32'(CLOCK_HZ / 1024);

   tsp_req_type req_ff;

   logic [CSR_DATA_W-1:0] gap_ff, gap_in;
   logic                  dual_ff, dual_in;

   logic [LEN_W-1:0]     active_len_ff, active_len_in;
   logic [LEN_W-1:0]     cur_ff, cur_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                 in_gap_ff, in_gap_in;
   logic                 active_ff, active_in;
   logic [FREQ_W-1:0]    sound_ff, sound_in;

   logic [3:0]           res_bits_ff, res_bits_in;
   logic [SHIFT_W-1:0]   res_shift_ff, res_shift_in;
   logic                 res_done_ff, res_done_in;

   tsp_rsp_type          rsp_ff;

   logic [FREQ_W+DUR_W-1:0] tone_mem [MAX_TONES];
   logic [FREQ_W+DUR_W-1:0] rd_ff;
   logic                    mem_we;
   logic [IDX_W-1:0]        wr_addr;
   logic [IDX_W-1:0]        rd_addr;

   logic [ELAPSED_W-1:0] elapsed_inc;
   logic [LEN_W-1:0]     cur_next;
   logic                 tone_over;
   logic                 gap_over;
   logic                 seq_over;
   logic [LEN_W-1:0]     len_sat;

   assign wr_addr = IDX_W'(req_ff.entry_index);
   assign rd_addr = cur_ff[IDX_W-1:0];
   assign mem_we  = cmd.apply && (req_ff.mode == MODE_WRITE) &&
                    (32'(req_ff.entry_index) < TONES_U);

   always_ff @(posedge clock) begin
      if (mem_we) tone_mem[wr_addr] <= {req_ff.entry_freq, req_ff.entry_duration};
      rd_ff <= tone_mem[rd_addr];
   end

   // tick arithmetic on the entry that was just read
   assign elapsed_inc = (elapsed_ff == {ELAPSED_W{1'b1}}) ? elapsed_ff
                                                          : elapsed_ff + 1'b1;
   assign cur_next  = cur_ff + 1'b1;
   assign tone_over = (elapsed_inc >= rd_ff[DUR_W-1:0]);
   assign gap_over  = (elapsed_inc >= ELAPSED_W'(gap_ff));
   assign seq_over  = (cur_next >= active_len_ff);
   assign len_sat   = (32'(req_ff.seq_length) > TONES_U) ? LEN_W'(MAX_TONES)
                                                         : LEN_W'(req_ff.seq_length);

   always_comb begin
      status.fetch_tick = (req_ff.mode == MODE_TICK) && active_ff;
      status.fetch_load = (req_ff.mode == MODE_START) && (req_ff.seq_length != 7'd0);
      status.need_load  = in_gap_ff && gap_over && !seq_over;
      status.res_done   = res_done_ff;
   end

   always_comb begin
      active_len_in = active_len_ff;
      cur_in        = cur_ff;
      elapsed_in    = elapsed_ff;
      in_gap_in     = in_gap_ff;
      active_in     = active_ff;
      sound_in      = sound_ff;

      if (cmd.apply) begin
         if (req_ff.mode == MODE_WRITE || req_ff.mode == MODE_START) begin
            active_in  = 1'b0;
            in_gap_in  = 1'b0;
            elapsed_in = '0;
            cur_in     = '0;
            sound_in   = '0;
         end
         if (req_ff.mode == MODE_START) begin
            active_len_in = len_sat;
            active_in     = (len_sat != '0);
         end
      end else if (cmd.update) begin
         elapsed_in = elapsed_inc;
         if (!in_gap_ff) begin
            if (tone_over) begin
               sound_in   = '0;
               elapsed_in = '0;
               in_gap_in  = 1'b1;
            end
         end else if (gap_over) begin
            elapsed_in = '0;
            in_gap_in  = 1'b0;
            if (seq_over) begin
               active_in = 1'b0;
               cur_in    = '0;
               sound_in  = '0;
            end else begin
               cur_in = cur_next;
            end
         end
      end else if (cmd.load_freq) begin
         sound_in = rd_ff[FREQ_W+DUR_W-1:DUR_W];
      end
   end

   // resolution search: one doubling of the frequency per step
   always_comb begin
      res_bits_in  = res_bits_ff;
      res_shift_in = res_shift_ff;
      res_done_in  = res_done_ff;
      if (cmd.res_init) begin
         res_bits_in  = RES_MIN_BITS;
         res_shift_in = SHIFT_W'(sound_ff) << RES_MIN_BITS;
         res_done_in  = 1'b0;
      end else if (cmd.res_step) begin
         priority if (sound_ff == '0) begin
            res_bits_in = RES_MAX_BITS;
            res_done_in = 1'b1;
         end else if (res_bits_ff == RES_MAX_BITS || 32'(res_shift_ff) > RES_NUM) begin
            res_done_in = 1'b1;
         end else begin
            res_bits_in  = res_bits_ff + 1'b1;
            res_shift_in = res_shift_ff << 1;
         end
      end
   end

   always_comb begin
      gap_in  = gap_ff;
      dual_in = dual_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GAP_MS:      gap_in  = csr_wdata;
            CSR_DUAL_OUTPUT: dual_in = csr_wdata[0];
            CSR_REST_LEVEL: begin
               // pin level only, no result field depends on it
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff        <= GAP_MS_RESET;
         dual_ff       <= 1'b0;
         active_len_ff <= '0;
         cur_ff        <= '0;
         elapsed_ff    <= '0;
         in_gap_ff     <= 1'b0;
         active_ff     <= 1'b0;
         sound_ff      <= '0;
         res_done_ff   <= 1'b0;
      end else begin
         gap_ff        <= gap_in;
         dual_ff       <= dual_in;
         active_len_ff <= active_len_in;
         cur_ff        <= cur_in;
         elapsed_ff    <= elapsed_in;
         in_gap_ff     <= in_gap_in;
         active_ff     <= active_in;
         sound_ff      <= sound_in;
         res_done_ff   <= res_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      res_bits_ff  <= res_bits_in;
      res_shift_ff <= res_shift_in;
      if (cmd.emit) begin
         rsp_ff.tone_freq      <= sound_ff;
         rsp_ff.res_width      <= res_bits_ff;
         rsp_ff.duty_value     <= (sound_ff != '0) ? (13'd1 << (res_bits_ff - 4'd1)) : 13'd0;
         rsp_ff.playing        <= active_ff;
         rsp_ff.second_enabled <= dual_ff;
      end
   end

   assign rsp_data = rsp_ff;

   `ASSERT_PROP(a_entry_in_range, clock, reset, !active_ff || (cur_ff < active_len_ff))
   `ASSERT_PROP(a_idle_clear, clock, reset,
      active_ff || (!in_gap_ff && elapsed_ff == '0 && sound_ff == '0))
   `ASSERT_PROP(a_res_range, clock, reset,
      !res_done_ff || (res_bits_ff >= RES_MIN_BITS && res_bits_ff <= RES_MAX_BITS))

endmodule
